### rtl/core/otpm_pkg.sv
// Package: sizes, codes, entry type and helpers of the ordered table block.
`default_nettype none

package otpm_pkg;

  localparam int unsigned CAPACITY   = 16;
  localparam int unsigned WORD_WIDTH = 32;
  localparam int unsigned FIELD_W    = 32;
  localparam int unsigned IDX_W      = $clog2(CAPACITY);
  localparam int unsigned CNT_W      = $clog2(CAPACITY + 1);

  typedef logic [WORD_WIDTH-1:0] word_t;
  typedef logic [FIELD_W-1:0]    field_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef enum logic [1:0] {
    OP_PUT       = 2'd0,
    OP_POP_MIN   = 2'd1,
    OP_POP_CLASS = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    word_t key;
    word_t cls;
    word_t prio;
    word_t pay;
  } ent_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    ent_t data;
  } wr_req_t;

  function automatic word_t to_word(input field_t f);
    return WORD_WIDTH'(f);
  endfunction

  function automatic field_t to_field(input word_t w);
    return FIELD_W'(w);
  endfunction

endpackage

`default_nettype wire

### rtl/core/ordered_table_pop_min_max_by_class_top.sv
// Top level: ordered table with put, pop-min and pop-max-by-class.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_ready_o | operation, key, class, priority, payload, class
//  out     | output    | out_valid_o/out_ready_i | status, key, class, priority, payload, empty
//
// Put, or a pop on an empty table, goes straight to the result. A pop scans the table and,
// when an entry is removed, compacts the entries behind it; its length is set by the single
// read port of the entry memory, which the scan and the compaction each walk one entry per
// cycle. Reset empties the table at once; no clearing pass.
// A finished result waits in the output register; the next transaction is taken meanwhile,
// and its result waits for the register to free up.
`default_nettype none

module ordered_table_pop_min_max_by_class_top
  import otpm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] key_value_i,
  input  wire logic [31:0] class_tag_i,
  input  wire logic [31:0] priority_value_i,
  input  wire logic [31:0] payload_value_i,
  input  wire logic [31:0] wanted_class_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       status_o,
  output logic [31:0]      out_key_o,
  output logic [31:0]      out_class_o,
  output logic [31:0]      out_priority_o,
  output logic [31:0]      out_payload_o,
  output logic             now_empty_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e  state_q, state_d;
  cnt_t    count_q, count_d;
  logic    out_valid_q, out_valid_d;

  op_e     op_q, op_d;
  word_t   want_q, want_d;
  cnt_t    idx_q, idx_d;
  logic    vld_q, vld_d;
  logic    found_q, found_d;
  idx_t    best_q, best_d;
  ent_t    best_ent_q, best_ent_d;
  status_e res_q, res_d;

  status_e out_status_q;
  ent_t    out_ent_q;
  logic    out_empty_q;

  wr_req_t wr;
  ent_t    rd_data;
  logic    accept;
  logic    hit;
  logic    load;

  otpm_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (idx_q[IDX_W-1:0]),
    .rd_data_o (rd_data)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load       = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    case (op_q)
      OP_POP_MIN:   hit = !found_q || (rd_data.key < best_ent_q.key);
      OP_POP_CLASS: hit = (rd_data.cls == want_q) &&
                          (!found_q || (rd_data.prio > best_ent_q.prio));
      default:      hit = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    op_d       = op_q;
    want_d     = want_q;
    idx_d      = idx_q;
    vld_d      = vld_q;
    found_d    = found_q;
    best_d     = best_q;
    best_ent_d = best_ent_q;
    res_d      = res_q;
    wr         = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = op_e'(operation_i);
          want_d  = to_word(wanted_class_i);
          idx_d   = '0;
          found_d = 1'b0;
          res_d   = ST_NONE;
          state_d = S_DONE;
          case (op_e'(operation_i))
            OP_PUT: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_d = ST_FULL;
              end else begin
                wr.en        = 1'b1;
                wr.addr      = count_q[IDX_W-1:0];
                wr.data.key  = to_word(key_value_i);
                wr.data.cls  = to_word(class_tag_i);
                wr.data.prio = to_word(priority_value_i);
                wr.data.pay  = to_word(payload_value_i);
                count_d      = count_q + CNT_W'(1);
                res_d        = ST_DONE;
              end
            end
            OP_POP_MIN, OP_POP_CLASS: begin
              if (count_q != '0) begin
                state_d = S_SCAN;
              end
            end
            default: begin
              res_d = ST_NONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_q != '0 && hit) begin
          found_d    = 1'b1;
          best_d     = IDX_W'(idx_q - CNT_W'(1));
          best_ent_d = rd_data;
        end
        if (idx_q != count_q) begin
          idx_d = idx_q + CNT_W'(1);
        end else if (found_d) begin
          idx_d   = CNT_W'(best_d) + CNT_W'(1);
          vld_d   = 1'b0;
          state_d = S_SHIFT;
        end else begin
          res_d   = ST_NONE;
          state_d = S_DONE;
        end
      end

      S_SHIFT: begin
        if (vld_q) begin
          wr.en   = 1'b1;
          wr.addr = IDX_W'(idx_q - CNT_W'(2));
          wr.data = rd_data;
        end
        if (idx_q != count_q) begin
          idx_d = idx_q + CNT_W'(1);
          vld_d = 1'b1;
        end else begin
          count_d = count_q - CNT_W'(1);
          res_d   = ST_DONE;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    want_q     <= want_d;
    idx_q      <= idx_d;
    vld_q      <= vld_d;
    found_q    <= found_d;
    best_q     <= best_d;
    best_ent_q <= best_ent_d;
    res_q      <= res_d;
    if (load) begin
      out_status_q <= res_q;
      out_ent_q    <= (res_q == ST_DONE && found_q) ? best_ent_q : '0;
      out_empty_q  <= (count_q == '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign out_key_o      = to_field(out_ent_q.key);
  assign out_class_o    = to_field(out_ent_q.cls);
  assign out_priority_o = to_field(out_ent_q.prio);
  assign out_payload_o  = to_field(out_ent_q.pay);
  assign now_empty_o    = out_empty_q;

endmodule

`default_nettype wire

### rtl/core/otpm_store.sv
// Entry memory: one write port, one read port with registered read data.
`default_nettype none

module otpm_store
  import otpm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire wr_req_t wr_i,
  input  wire idx_t    rd_addr_i,
  output ent_t         rd_data_o
);

  ent_t mem [CAPACITY];
  ent_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

### rtl/core/otpm_checker.sv
// Checker: port-level properties of the ordered table block, bound to the top level.
`default_nettype none

module otpm_checker
  import otpm_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  status_o,
  input wire logic [31:0] out_key_o,
  input wire logic [31:0] out_class_o,
  input wire logic [31:0] out_priority_o,
  input wire logic [31:0] out_payload_o,
  input wire logic        now_empty_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(out_key_o)
      && $stable(out_payload_o) && $stable(now_empty_o))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE) || (status_o == ST_NONE) || (status_o == ST_FULL))
    else $error("unused status code");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_DONE |-> out_key_o == '0 && out_class_o == '0
      && out_priority_o == '0 && out_payload_o == '0)
    else $error("fields not zero on failed transaction");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> !now_empty_o)
    else $error("full table reported empty");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted a transaction while busy");

endmodule

bind ordered_table_pop_min_max_by_class_top otpm_checker u_otpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .status_o       (status_o),
  .out_key_o      (out_key_o),
  .out_class_o    (out_class_o),
  .out_priority_o (out_priority_o),
  .out_payload_o  (out_payload_o),
  .now_empty_o    (now_empty_o)
);

`default_nettype wire

### test/ordered_table_pop_min_max_by_class_top_tb.sv
// Testbench: random and directed put/pop traffic checked against a behavioral model of the table.
module ordered_table_pop_min_max_by_class_top_tb;
  import otpm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned RANDOM_OPS = 950;
  localparam int unsigned TAIL_CYCLES = 80;

  typedef struct {
    logic [1:0] opcode;
    field_t     key;
    field_t     cls;
    field_t     prio;
    field_t     pay;
    field_t     want;
    bit         drain_first;
  } table_op_t;

  typedef struct packed {
    status_e status;
    field_t  key;
    field_t  cls;
    field_t  prio;
    field_t  pay;
    logic    empty;
  } table_result_t;

  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i      = OP_PUT;
  logic [31:0] key_value_i      = '0;
  logic [31:0] class_tag_i      = '0;
  logic [31:0] priority_value_i = '0;
  logic [31:0] payload_value_i  = '0;
  logic [31:0] wanted_class_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] out_key_o;
  logic [31:0] out_class_o;
  logic [31:0] out_priority_o;
  logic [31:0] out_payload_o;
  logic        now_empty_o;

  ordered_table_pop_min_max_by_class_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .key_value_i     (key_value_i),
    .class_tag_i     (class_tag_i),
    .priority_value_i(priority_value_i),
    .payload_value_i (payload_value_i),
    .wanted_class_i  (wanted_class_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .out_key_o       (out_key_o),
    .out_class_o     (out_class_o),
    .out_priority_o  (out_priority_o),
    .out_payload_o   (out_payload_o),
    .now_empty_o     (now_empty_o)
  );

  table_op_t     pending_ops[$];
  table_result_t expected_results[$];
  int unsigned   total_ops;
  int unsigned   accepted_count = 0;
  int unsigned   result_count   = 0;
  int unsigned   check_errors   = 0;

  word_t       held_key  [CAPACITY];
  word_t       held_cls  [CAPACITY];
  word_t       held_prio [CAPACITY];
  word_t       held_pay  [CAPACITY];
  int unsigned held_count = 0;

  field_t class_pool[4];

  function automatic void remove_entry(input int unsigned slot, inout table_result_t r);
    r.key  = field_t'(held_key[slot]);
    r.cls  = field_t'(held_cls[slot]);
    r.prio = field_t'(held_prio[slot]);
    r.pay  = field_t'(held_pay[slot]);
    for (int unsigned i = slot; i + 1 < held_count; i++) begin
      held_key[i]  = held_key[i+1];
      held_cls[i]  = held_cls[i+1];
      held_prio[i] = held_prio[i+1];
      held_pay[i]  = held_pay[i+1];
    end
    held_count--;
    r.status = ST_DONE;
  endfunction

  function automatic table_result_t predict_table_op(input table_op_t op);
    table_result_t r;
    int unsigned   best;
    bit            found;
    r        = '0;
    r.status = ST_NONE;
    best     = 0;
    found    = 1'b0;
    case (op.opcode)
      OP_PUT: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_key[held_count]  = word_t'(op.key);
          held_cls[held_count]  = word_t'(op.cls);
          held_prio[held_count] = word_t'(op.prio);
          held_pay[held_count]  = word_t'(op.pay);
          held_count++;
          r.status = ST_DONE;
        end
      end
      OP_POP_MIN: begin
        if (held_count > 0) begin
          for (int unsigned i = 1; i < held_count; i++)
            if (held_key[i] < held_key[best]) best = i;
          remove_entry(best, r);
        end
      end
      OP_POP_CLASS: begin
        for (int unsigned i = 0; i < held_count; i++) begin
          if (held_cls[i] == word_t'(op.want) && (!found || held_prio[i] > held_prio[best])) begin
            best  = i;
            found = 1'b1;
          end
        end
        if (found) remove_entry(best, r);
      end
      default: ;
    endcase
    r.empty = (held_count == 0);
    return r;
  endfunction

  function automatic table_op_t make_op(input logic [1:0] opcode, input field_t key,
                                        input field_t cls, input field_t prio,
                                        input field_t pay, input field_t want);
    table_op_t op;
    op.opcode      = opcode;
    op.key         = key;
    op.cls         = cls;
    op.prio        = prio;
    op.pay         = pay;
    op.want        = want;
    op.drain_first = 1'b0;
    return op;
  endfunction

  function automatic field_t pick_ordering_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return field_t'($urandom_range(0, 15));
    if (roll < 45) return '0;
    if (roll < 50) return '1;
    return $urandom;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
      check_errors++;
    end
  endfunction

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk_i) begin : drive_ops
    bit          fire;
    table_op_t   nxt;
    int unsigned burst_left;
    int unsigned idle_left;
    if (rst_ni) begin
      fire = in_valid_i && in_ready_o;
      if (fire) accepted_count <= accepted_count + 1;
      if (!in_valid_i || fire) begin
        if (idle_left > 0) begin
          idle_left--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() > 0 &&
                     !(pending_ops[0].drain_first && accepted_count + fire != result_count)) begin
          nxt = pending_ops.pop_front();
          operation_i      <= nxt.opcode;
          key_value_i      <= nxt.key;
          class_tag_i      <= nxt.cls;
          priority_value_i <= nxt.prio;
          payload_value_i  <= nxt.pay;
          wanted_class_i   <= nxt.want;
          in_valid_i       <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 10);
            idle_left  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end else begin
      burst_left = 1;
      idle_left  = 0;
    end
  end

  always @(posedge clk_i) begin : drive_ready
    int unsigned mode_left;
    int unsigned stall_mode;
    int unsigned tick;
    tick++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 1) == 1);
      2:       out_ready_i <= ($urandom_range(0, 5) == 0);
      default: out_ready_i <= ((tick % 16) >= 6);
    endcase
  end

  always @(posedge clk_i) begin : check_results
    table_result_t exp_r;
    table_op_t     seen;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, key 0x%08h", status_o, out_key_o);
          check_errors++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("status", 32'(exp_r.status), 32'(status_o));
          check_field("out_key", exp_r.key, out_key_o);
          check_field("out_class", exp_r.cls, out_class_o);
          check_field("out_priority", exp_r.prio, out_priority_o);
          check_field("out_payload", exp_r.pay, out_payload_o);
          check_field("now_empty", 32'(exp_r.empty), 32'(now_empty_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        seen = make_op(operation_i, key_value_i, class_tag_i, priority_value_i,
                       payload_value_i, wanted_class_i);
        expected_results.push_back(predict_table_op(seen));
      end
    end
  end

  initial begin : run_stimulus
    bit          filling;
    int unsigned phase_left;
    int unsigned roll;
    table_op_t   op;

    class_pool[0] = '0;
    class_pool[1] = '1;
    class_pool[2] = $urandom;
    class_pool[3] = $urandom;

    // empty table, unused code, extremes, ties
    pending_ops.push_back(make_op(OP_POP_MIN, '1, '1, '1, '1, '1));
    pending_ops.push_back(make_op(OP_POP_CLASS, '0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_UNUSED, '1, '1, '1, '1, '1));
    pending_ops.push_back(make_op(OP_PUT, '1, '0, '0, '1, '0));
    pending_ops.push_back(make_op(OP_PUT, '0, '1, '1, '0, '1));
    pending_ops.push_back(make_op(OP_PUT, '0, '1, '1, 32'd1, '0));
    pending_ops.push_back(make_op(OP_UNUSED, '0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_POP_CLASS, '0, '0, '0, '0, 32'h1234_5678));
    pending_ops.push_back(make_op(OP_POP_CLASS, '0, '0, '0, '0, '1));
    pending_ops.push_back(make_op(OP_POP_MIN, '0, '0, '0, '0, '0));
    pending_ops.push_back(make_op(OP_POP_MIN, '0, '0, '0, '0, '0));
    // fill past capacity
    for (int unsigned i = 0; i <= CAPACITY; i++)
      pending_ops.push_back(make_op(OP_PUT, $urandom, class_pool[i % 4], $urandom,
                                    $urandom, $urandom));

    filling    = 1'b0;
    phase_left = 0;
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      op = make_op(OP_PUT, pick_ordering_word(), class_pool[$urandom_range(0, 3)],
                   pick_ordering_word(), $urandom, class_pool[$urandom_range(0, 3)]);
      if ($urandom_range(0, 9) == 0) op.cls = $urandom;
      if ($urandom_range(0, 6) == 0) op.want = $urandom;
      if (phase_left == 0) begin
        filling        = !filling;
        phase_left     = $urandom_range(5, 40);
        op.drain_first = (n == 0) || ($urandom_range(0, 2) == 0);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (roll < 2)
        op.opcode = OP_UNUSED;
      else if (roll < (filling ? 78 : 28))
        op.opcode = OP_PUT;
      else
        op.opcode = $urandom_range(0, 1) ? OP_POP_MIN : OP_POP_CLASS;
      pending_ops.push_back(op);
    end
    total_ops = pending_ops.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count != total_ops || result_count != total_ops) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      check_errors++;
    end
    if (check_errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
